[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge outside reset
`define PIF_ASSERT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds at a clock edge outside reset
`define PIF_NEVER(name, clk, rstn, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PIF_ASSERT(name, clk, rstn, prop, msg)
`define PIF_NEVER(name, clk, rstn, expr, msg)
`endif

`endif

[design/pif_pkg.sv]
// ----------------------------------------------------------------------------
// pif_pkg
// Types and constants shared by the padded integer formatter modules.
// ----------------------------------------------------------------------------
package pif_pkg;

	// Field widths fixed by the interface
	localparam int VALUE_W     = 32;
	localparam int FWIDTH_W    = 6;
	localparam int JOB_WIDTH_W = 7;

	// Parameter defaults
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_WIDTH_DEF  = 32;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Digit arithmetic
	localparam int DEC_BASE = 10;

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_UPPER = 8'h41;

	// Input item
	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic                base_hex;
		logic                signed_mode;
		logic [FWIDTH_W-1:0] field_width;
		logic [1:0]          pad_mode;
		logic                upper_case;
	} pif_in_t;

	// Result item
	typedef struct packed {
		logic [7:0] out_char;
		logic       is_last;
	} pif_out_t;

	// Classified job handed from front to back
	typedef struct packed {
		logic [VALUE_W-1:0]     mag;
		logic [JOB_WIDTH_W-1:0] width;
		logic                   neg;
		logic                   hex;
		logic                   left;
		logic                   zfill;
		logic                   upper;
	} pif_job_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} pif_qstat_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_HEX,
		ST_LAYOUT,
		ST_EMIT
	} pif_state_t;

endpackage

[design/pif_front.sv]
// ----------------------------------------------------------------------------
// pif_front
// Accepts input items and classifies them: sign, magnitude, width, fill.
// ----------------------------------------------------------------------------
module pif_front #(
	parameter int VALUE_BITS = pif_pkg::VALUE_BITS_DEF,
	parameter int MAX_WIDTH  = pif_pkg::MAX_WIDTH_DEF
) (
	input  logic                start,
	input  pif_pkg::pif_in_t    item,
	input  pif_pkg::pif_qstat_t qstat,
	output logic                busy,
	output logic                push,
	output pif_pkg::pif_job_t   job
);

	localparam int MAG_BITS = (VALUE_BITS < pif_pkg::VALUE_W) ? VALUE_BITS : pif_pkg::VALUE_W;
	localparam logic SIGN_ON = (VALUE_BITS <= pif_pkg::VALUE_W);
	localparam logic [pif_pkg::JOB_WIDTH_W-1:0] WMAX = pif_pkg::JOB_WIDTH_W'(MAX_WIDTH);

	logic [MAG_BITS-1:0]             v;
	logic                            neg;
	logic [MAG_BITS-1:0]             mag;
	logic [pif_pkg::JOB_WIDTH_W-1:0] fw;

	// Hold off new transactions while the queue is full
	assign busy = qstat.full;
	assign push = start && !busy;

	// Classify the item
	always_comb begin
		v   = item.value[MAG_BITS-1:0];
		neg = SIGN_ON && !item.base_hex && item.signed_mode && v[MAG_BITS-1];
		mag = neg ? (MAG_BITS'(0) - v) : v;
		fw  = pif_pkg::JOB_WIDTH_W'(item.field_width);
		job.mag   = pif_pkg::VALUE_W'(mag);
		job.width = (fw > WMAX) ? WMAX : fw;
		job.neg   = neg;
		job.hex   = item.base_hex;
		job.left  = item.pad_mode[0];
		job.zfill = item.pad_mode[1] && !item.pad_mode[0];
		job.upper = item.upper_case;
	end

endmodule

[design/pif_queue.sv]
// ----------------------------------------------------------------------------
// pif_queue
// Short job queue decoupling the front classifier from the back sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pif_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pif_pkg::pif_job_t   push_data,
	input  logic                pop,
	output pif_pkg::pif_job_t   pop_data,
	output pif_pkg::pif_qstat_t qstat
);

	localparam int PTR_W = $clog2(pif_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(pif_pkg::QUEUE_DEPTH + 1);

	pif_pkg::pif_job_t slot_q [pif_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign qstat.full  = (cnt_q == CNT_W'(pif_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = slot_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(pif_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(pif_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	`PIF_NEVER(a_push_full, clk, arst_n, push && qstat.full, "push into full queue")
	`PIF_NEVER(a_pop_empty, clk, arst_n, pop && qstat.empty, "pop from empty queue")
	`PIF_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(pif_pkg::QUEUE_DEPTH), "count overrun")

endmodule

[design/pif_back.sv]
// ----------------------------------------------------------------------------
// pif_back
// Converts a job to digits (divide by ten or nibble split) and emits the
// padded field one character per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pif_back #(
	parameter int VALUE_BITS = pif_pkg::VALUE_BITS_DEF,
	parameter int MAX_WIDTH  = pif_pkg::MAX_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pif_pkg::pif_qstat_t qstat,
	input  pif_pkg::pif_job_t   pop_data,
	output logic                pop,
	output logic                strobe,
	output pif_pkg::pif_out_t   result
);

	localparam int MAG_BITS  = (VALUE_BITS < pif_pkg::VALUE_W) ? VALUE_BITS : pif_pkg::VALUE_W;
	localparam int DIGITS    = (MAG_BITS * 31) / 100 + 1;
	localparam int DIG_IDX   = $clog2(DIGITS);
	localparam int ND_BITS   = $clog2(DIGITS + 1);
	localparam int LINE_BITS = $clog2(MAX_WIDTH + DIGITS + 2);
	localparam int PROD_W    = 2 * MAG_BITS;
	localparam int SHIFT     = MAG_BITS + 3;
	localparam logic [MAG_BITS+3:0] POW = {1'b1, {(MAG_BITS + 3){1'b0}}};
	localparam logic [MAG_BITS+3:0] RECIP_FULL = POW / pif_pkg::DEC_BASE;
	localparam logic [MAG_BITS-1:0] RECIP = RECIP_FULL[MAG_BITS-1:0];
	localparam logic [MAG_BITS-1:0] TEN = MAG_BITS'(pif_pkg::DEC_BASE);

	pif_pkg::pif_state_t state_q, state_d;

	pif_pkg::pif_job_t    job_q;
	logic [MAG_BITS-1:0]  mag_q;
	logic [PROD_W-1:0]    prod_q;
	logic [ND_BITS-1:0]   nd_q;
	logic [3:0]           dig_q [DIGITS];
	logic [LINE_BITS-1:0] b1_q, b2_q, b3_q, b4_q, total_q, pos_q;

	logic [MAG_BITS-1:0]  q0, r0, q_fix, r_fix;
	logic [MAG_BITS-1:0]  mag_shr;
	logic [LINE_BITS-1:0] len, wid, excess, lay_b1, lay_b2, lay_b3, lay_b4, lay_total;
	logic                 wide;
	logic [LINE_BITS-1:0] dig_pos;
	logic [3:0]           dsel;
	logic                 last;

	// Divide-by-ten correction step
	always_comb begin
		q0    = MAG_BITS'(prod_q[PROD_W-1:SHIFT]);
		r0    = mag_q - ((q0 << 3) + (q0 << 1));
		q_fix = (r0 >= TEN) ? q0 + 1'b1 : q0;
		r_fix = (r0 >= TEN) ? r0 - TEN : r0;
	end

	assign mag_shr = mag_q >> 4;

	// Field layout from digit count, sign, width and fill
	always_comb begin
		len    = LINE_BITS'(nd_q) + LINE_BITS'(job_q.neg);
		wid    = LINE_BITS'(job_q.width);
		wide   = wid > len;
		excess = wide ? wid - len : '0;
		lay_b1 = LINE_BITS'(job_q.neg && (job_q.zfill || job_q.left || !wide));
		lay_b2 = lay_b1 + (job_q.left ? '0 : excess);
		lay_b3 = lay_b2 + LINE_BITS'(job_q.neg && !job_q.zfill && !job_q.left && wide);
		lay_b4 = lay_b3 + LINE_BITS'(nd_q);
		lay_total = lay_b4 + (job_q.left ? excess : '0);
	end

	// Select the character at the current position
	always_comb begin
		dig_pos = b4_q - 1'b1 - pos_q;
		dsel    = dig_q[dig_pos[DIG_IDX-1:0]];
		last    = (pos_q == total_q - 1'b1);
		result.is_last = last;
		if (pos_q < b1_q) begin
			result.out_char = pif_pkg::CH_MINUS;
		end else if (pos_q < b2_q) begin
			result.out_char = job_q.zfill ? pif_pkg::CH_ZERO : pif_pkg::CH_SPACE;
		end else if (pos_q < b3_q) begin
			result.out_char = pif_pkg::CH_MINUS;
		end else if (pos_q < b4_q) begin
			if (dsel < 4'(pif_pkg::DEC_BASE)) begin
				result.out_char = pif_pkg::CH_ZERO + 8'(dsel);
			end else begin
				result.out_char = (job_q.upper ? pif_pkg::CH_UPPER : pif_pkg::CH_LOWER)
					+ 8'(dsel) - 8'(pif_pkg::DEC_BASE);
			end
		end else begin
			result.out_char = pif_pkg::CH_SPACE;
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pif_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		strobe  = 1'b0;
		unique case (state_q)
			pif_pkg::ST_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = pop_data.hex ? pif_pkg::ST_HEX : pif_pkg::ST_MUL;
				end
			end
			pif_pkg::ST_MUL: begin
				state_d = pif_pkg::ST_FIX;
			end
			pif_pkg::ST_FIX: begin
				state_d = (q_fix == '0) ? pif_pkg::ST_LAYOUT : pif_pkg::ST_MUL;
			end
			pif_pkg::ST_HEX: begin
				if (mag_shr == '0) begin
					state_d = pif_pkg::ST_LAYOUT;
				end
			end
			pif_pkg::ST_LAYOUT: begin
				state_d = pif_pkg::ST_EMIT;
			end
			pif_pkg::ST_EMIT: begin
				strobe = 1'b1;
				if (last) begin
					state_d = pif_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pif_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath: load, digit steps, layout, emit position
	always_ff @(posedge clk) begin
		unique case (state_q)
			pif_pkg::ST_IDLE: begin
				job_q <= pop_data;
				mag_q <= pop_data.mag[MAG_BITS-1:0];
				nd_q  <= '0;
			end
			pif_pkg::ST_MUL: begin
				prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP);
			end
			pif_pkg::ST_FIX: begin
				dig_q[nd_q[DIG_IDX-1:0]] <= r_fix[3:0];
				nd_q  <= nd_q + 1'b1;
				mag_q <= q_fix;
			end
			pif_pkg::ST_HEX: begin
				dig_q[nd_q[DIG_IDX-1:0]] <= mag_q[3:0];
				nd_q  <= nd_q + 1'b1;
				mag_q <= mag_shr;
			end
			pif_pkg::ST_LAYOUT: begin
				b1_q    <= lay_b1;
				b2_q    <= lay_b2;
				b3_q    <= lay_b3;
				b4_q    <= lay_b4;
				total_q <= lay_total;
				pos_q   <= '0;
			end
			pif_pkg::ST_EMIT: begin
				pos_q <= pos_q + 1'b1;
			end
			default: begin
				pos_q <= '0;
			end
		endcase
	end

	`PIF_ASSERT(a_last_ends, clk, arst_n, (strobe && result.is_last) |=> !strobe,
		"character after last")
	`PIF_ASSERT(a_no_gap, clk, arst_n, (strobe && !result.is_last) |=> strobe,
		"gap inside a field")
	`PIF_ASSERT(a_digit_room, clk, arst_n,
		(state_q == pif_pkg::ST_FIX || state_q == pif_pkg::ST_HEX) |-> (nd_q < ND_BITS'(DIGITS)),
		"digit buffer overrun")

endmodule

[design/padded_integer_formatter_unit.sv]
// ----------------------------------------------------------------------------
// padded_integer_formatter_unit
// Formats one integer per transaction as printf-style decimal or hex text,
// padded to a field width, one ASCII character per result.
// ----------------------------------------------------------------------------
//  channel   signals              handshake
//  input     start, busy, item    taken at clk edge with start && !busy
//  output    strobe, result       one character per cycle, no back-pressure
//
//  Steps: an item enters a two-entry job queue. The back end loads it, then
//  makes each decimal digit by a reciprocal multiply and then a correction,
//  or each hex digit by a nibble split, then lays out the field and emits
//  its characters.
//  busy rises only while the job queue is full.
//  Reset clears the queue and the sequencer; no pass over storage is needed.
// ----------------------------------------------------------------------------
module padded_integer_formatter_unit #(
	parameter int VALUE_BITS = pif_pkg::VALUE_BITS_DEF,
	parameter int MAX_WIDTH  = pif_pkg::MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pif_pkg::pif_in_t  item,
	output logic              busy,
	output logic              strobe,
	output pif_pkg::pif_out_t result
);

	pif_pkg::pif_qstat_t qstat;
	pif_pkg::pif_job_t   push_job;
	pif_pkg::pif_job_t   pop_job;
	logic                push;
	logic                pop;

	// Classify incoming transactions
	pif_front #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_front (
		.start (start),
		.item  (item),
		.qstat (qstat),
		.busy  (busy),
		.push  (push),
		.job   (push_job)
	);

	// Buffer classified jobs
	pif_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.qstat     (qstat)
	);

	// Generate digits and emit characters
	pif_back #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_job),
		.pop      (pop),
		.strobe   (strobe),
		.result   (result)
	);

endmodule
